[sv/mse_pkg.sv]
// ----------------------------------------------------------------------------
// mse_pkg: shared definitions for the MIPS integer subset execute block
// Field widths, opcode and funct codes, result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);
  localparam int WORD_W    = 32;
  localparam int PC_BITS   = 16;
  localparam int OUT_PC_W  = 16;
  localparam int IMM_W     = 16;
  localparam int IMM_SHIFT = 16;

  localparam logic [5:0] OP_RTYPE   = 6'h00;
  localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;

  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MUL     = 6'h02;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SYSCALL = 2'd2
  } status_t;

  function automatic logic [WORD_W-1:0] slt_word(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    slt_word = {{(WORD_W-1){1'b0}}, ($signed(a) < $signed(b))};
  endfunction

endpackage

`default_nettype wire

[sv/mse_chan_if.sv]
// ----------------------------------------------------------------------------
// mse_chan_if: valid/ready channels of the execute block
// One channel carries instruction words in, the other carries results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mse_in_if;
  import mse_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mse_out_if;
  import mse_pkg::*;
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic                     reg_written;
  logic [REG_AW-1:0]        dest_index;
  logic signed [WORD_W-1:0] dest_value;
  logic [OUT_PC_W-1:0]      next_pc;

  modport source (output valid, output status, output reg_written, output dest_index,
                  output dest_value, output next_pc, input ready);
  modport sink   (input valid, input status, input reg_written, input dest_index,
                  input dest_value, input next_pc, output ready);
endinterface

`default_nettype wire

[sv/mse_ram.sv]
// ----------------------------------------------------------------------------
// mse_ram: generic single-write, single-read RAM
// Read data is registered and holds while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/mips_subset_execute.sv]
// ----------------------------------------------------------------------------
// mips_subset_execute: execute stage for a MIPS32 integer subset
// Decodes one instruction word per transfer, runs it against the register
// file and the program counter, and returns one result per instruction.
// ----------------------------------------------------------------------------
// Pipeline: the register file is read into stage 1 on the input transfer;
//   execute and write-back happen as it moves into the output register.
// Throughput: one instruction per cycle unless the output stalls; the register
//   file RAMs are read on transfer and written as the instruction leaves execute.
// Reset: PC goes to zero and the per-register valid bits clear, so every
//   register reads as zero at once; no clearing pass is needed.
`default_nettype none

module mips_subset_execute
  import mse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mse_in_if.sink     in_ch,
  mse_out_if.source  out_ch
);

  logic                 in_xfer;
  logic                 s1_valid_r;
  logic [WORD_W-1:0]    s1_instr_r;
  logic                 s1_adv;

  logic [5:0]           op;
  logic [5:0]           fn;
  logic [REG_AW-1:0]    rs;
  logic [REG_AW-1:0]    rt;
  logic [REG_AW-1:0]    rd;
  logic [IMM_W-1:0]     imm;
  logic [WORD_W-1:0]    imm_sx;
  logic [WORD_W-1:0]    imm_zx;

  logic [WORD_W-1:0]    ram_a;
  logic [WORD_W-1:0]    ram_b;
  logic [WORD_W-1:0]    opa;
  logic [WORD_W-1:0]    opb;

  logic [REG_COUNT-1:0] valid_r;
  logic                 fwd_valid_r;
  logic [REG_AW-1:0]    fwd_idx_r;
  logic [WORD_W-1:0]    fwd_val_r;

  status_t              status;
  logic                 wr;
  logic [REG_AW-1:0]    dst;
  logic [WORD_W-1:0]    val;
  logic                 taken;
  logic                 wr_en;

  logic [PC_BITS-1:0]   pc_r;
  logic [PC_BITS-1:0]   pc_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic                 out_wr_r;
  logic [REG_AW-1:0]    out_dst_r;
  logic [WORD_W-1:0]    out_val_r;
  logic [OUT_PC_W-1:0]  out_pc_r;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;

  // Two copies of the register file give two read ports; both take every write.
  mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (dst),
    .wdata (val),
    .re    (in_xfer),
    .raddr (in_ch.instruction_word[25:21]),
    .rdata (ram_a)
  );

  mse_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (dst),
    .wdata (val),
    .re    (in_xfer),
    .raddr (in_ch.instruction_word[20:16]),
    .rdata (ram_b)
  );

  assign op     = s1_instr_r[31:26];
  assign rs     = s1_instr_r[25:21];
  assign rt     = s1_instr_r[20:16];
  assign rd     = s1_instr_r[15:11];
  assign fn     = s1_instr_r[5:0];
  assign imm    = s1_instr_r[15:0];
  assign imm_sx = {{(WORD_W-IMM_W){imm[IMM_W-1]}}, imm};
  assign imm_zx = {{(WORD_W-IMM_W){1'b0}}, imm};

  // The write that lands in the same cycle as a read is not seen by the RAM,
  // so the most recent write is kept aside and forwarded. No write happens
  // while an instruction waits in execute, so one entry is enough.
  always_comb begin
    if (rs == '0) begin
      opa = '0;
    end else if (fwd_valid_r && (fwd_idx_r == rs)) begin
      opa = fwd_val_r;
    end else if (!valid_r[rs]) begin
      opa = '0;
    end else begin
      opa = ram_a;
    end
    if (rt == '0) begin
      opb = '0;
    end else if (fwd_valid_r && (fwd_idx_r == rt)) begin
      opb = fwd_val_r;
    end else if (!valid_r[rt]) begin
      opb = '0;
    end else begin
      opb = ram_b;
    end
  end

  always_comb begin
    status = ST_OK;
    wr     = 1'b0;
    dst    = '0;
    val    = '0;
    taken  = 1'b0;
    if (op == OP_RTYPE) begin
      dst = rd;
      wr  = 1'b1;
      case (fn)
        FN_ADD:     val = opa + opb;
        FN_SUB:     val = opa - opb;
        FN_AND:     val = opa & opb;
        FN_OR:      val = opa | opb;
        FN_SLT:     val = slt_word(opa, opb);
        FN_SYSCALL: begin
          wr     = 1'b0;
          status = ST_SYSCALL;
        end
        default: begin
          wr     = 1'b0;
          status = ST_INVALID;
        end
      endcase
    end else if (op == OP_SPECIAL2) begin
      if (fn == FN_MUL) begin
        dst = rd;
        wr  = 1'b1;
        val = opa * opb;
      end else begin
        status = ST_INVALID;
      end
    end else begin
      dst = rt;
      wr  = 1'b1;
      case (op)
        OP_LUI:  val = imm_zx << IMM_SHIFT;
        OP_ORI:  val = opa | imm_zx;
        OP_ANDI: val = opa & imm_zx;
        OP_ADDI: val = opa + imm_sx;
        OP_SLTI: val = slt_word(opa, imm_sx);
        OP_BEQ: begin
          wr    = 1'b0;
          taken = (opa == opb);
        end
        OP_BNE: begin
          wr    = 1'b0;
          taken = (opa != opb);
        end
        default: begin
          wr     = 1'b0;
          status = ST_INVALID;
        end
      endcase
    end
    // Writes to register zero are dropped and reported as no write.
    if (!wr || (dst == '0)) begin
      wr  = 1'b0;
      dst = '0;
      val = '0;
    end
  end

  assign wr_en  = s1_adv && wr;
  assign pc_nxt = taken ? (pc_r + PC_BITS'(imm_sx)) : (pc_r + PC_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        pc_r        <= pc_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        valid_r[dst] <= 1'b1;
        fwd_valid_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_instr_r <= in_ch.instruction_word;
    end
    if (wr_en) begin
      fwd_idx_r <= dst;
      fwd_val_r <= val;
    end
    if (s1_adv) begin
      out_status_r <= status;
      out_wr_r     <= wr;
      out_dst_r    <= dst;
      out_val_r    <= val;
      out_pc_r     <= OUT_PC_W'(pc_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.reg_written = out_wr_r;
  assign out_ch.dest_index  = out_dst_r;
  assign out_ch.dest_value  = out_val_r;
  assign out_ch.next_pc     = out_pc_r;

  a_no_write_r0: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (dst != '0))
    else $error("register zero written");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (fwd_valid_r && (fwd_idx_r == $past(dst)) && (fwd_val_r == $past(val))))
    else $error("forwarding entry does not hold the last write");

  a_no_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wr_r) |-> ((out_dst_r == '0) && (out_val_r == '0)))
    else $error("result without write carries a destination");

  a_status_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> !out_wr_r)
    else $error("invalid or syscall instruction wrote a register");

  a_pc_moves_once: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> (pc_r == $past(pc_r)))
    else $error("PC changed without an instruction retiring");

endmodule

`default_nettype wire
